[sv/assert_macros.svh]
// Assertion macros used by the parser RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising clk edge outside reset.
`define RDPP_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Condition that must never be seen outside reset.
`define RDPP_ASSERT_NEVER(lbl, cond, msg) \
    `RDPP_ASSERT(lbl, !(cond), msg)

`endif

[sv/rdpp_pkg.sv]
// Types, constants and helper functions of the rangefinder protocol parser.
package rdpp_pkg;

    localparam int LINE_LEN_DEF  = 16;
    localparam int MAX_BATCH_DEF = 8192;

    localparam int DIST_W  = 15;
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;

    localparam logic [DIST_W-1:0] MAX_DIST_RST = 15'd4000;
    localparam logic [DIST_W-1:0] DIST_SAT     = 15'h7fff;
    localparam logic [15:0]       OOR_MIN_CM   = 16'd10000;
    localparam logic [15:0]       OOR_ADD_CM   = 16'd100;
    localparam logic [3:0]        GOOD_LOCK    = 4'd10;

    localparam logic [DIST_W-1:0] LOST_CODE0 = 15'd13000;
    localparam logic [DIST_W-1:0] LOST_CODE1 = 15'd16000;
    localparam logic [DIST_W-1:0] LOST_CODE2 = 15'd23000;
    localparam logic [DIST_W-1:0] LOST_CODE3 = 15'd25000;

    localparam logic [7:0] CH_CR    = 8'h0d;
    localparam logic [7:0] CH_MINUS = 8'h2d;
    localparam logic [7:0] CH_DOT   = 8'h2e;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    localparam logic MODE_BYTE = 1'b0;
    localparam logic MODE_END  = 1'b1;

    localparam logic [1:0] PROTO_UNKNOWN = 2'd0;
    localparam logic [1:0] PROTO_ASCII   = 2'd1;
    localparam logic [1:0] PROTO_BINARY  = 2'd2;

    typedef struct packed {
        logic [1:0] frac_cnt;
        logic       nz;
        logic       stop;
        logic       dot;
        logic       neg;
    } ascii_flags_t;

    function automatic logic is_lost(input logic [DIST_W-1:0] cm,
                                     input logic [DIST_W-1:0] max_cm);
        logic [15:0] lim;
        lim = {1'b0, max_cm} + OOR_ADD_CM;
        return ({1'b0, cm} >= lim) &&
               (cm == LOST_CODE0 || cm == LOST_CODE1 ||
                cm == LOST_CODE2 || cm == LOST_CODE3);
    endfunction

    function automatic logic [DIST_W-1:0] sat_dist(input logic [18:0] v);
        return (v > 19'(DIST_SAT)) ? DIST_SAT : v[DIST_W-1:0];
    endfunction

endpackage

[sv/rangefinder_dual_protocol_parser.sv]
// Rangefinder byte parser: ASCII and binary protocols, batch average by serial divider.
// Byte word: taken every idle cycle, parsed combinationally, no result.
// End-of-batch word: the result is computed in ST_DIV, one quotient bit per cycle, or goes
//   straight to ST_FIN when there is no valid reading; input stalls until the result
//   enters the output register, so no new word is taken while a batch result is pending.
// rst_n clears parser, counters and batch state asynchronously; max distance 4000.
module rangefinder_dual_protocol_parser
    import rdpp_pkg::*;
#(
    parameter int LINE_LEN  = LINE_LEN_DEF,
    parameter int MAX_BATCH = MAX_BATCH_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic               mode,
    input  logic [7:0]         byte_value,
    output logic               out_valid,
    input  logic               out_stall,
    output logic               has_reading,
    output logic [DIST_W-1:0]  range_cm,
    output logic               lost_flag,
    output logic [1:0]         protocol
);

    localparam int LEN_W = $clog2(LINE_LEN);
    localparam int CNT_W = $clog2(MAX_BATCH + 1);
    localparam int SUM_W = CNT_W + DIST_W;
    localparam int ITR_W = $clog2(SUM_W);

    localparam logic [3:0] GOOD_MAX = GOOD_LOCK + 4'd1;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_DIV  = 2'd1;
    localparam logic [1:0] ST_FIN  = 2'd2;

    logic [DIST_W-1:0] max_reg, max_next;
    logic [1:0]        state_reg, state_next;
    logic [1:0]        proto_reg, proto_next;
    logic [DIST_W-1:0] a_val_reg, a_val_next;
    ascii_flags_t      a_flags_reg, a_flags_next;
    logic [LEN_W-1:0]  a_len_reg, a_len_next;
    logic [6:0]        high_reg, high_next;
    logic              high_seen_reg, high_seen_next;
    logic [3:0]        a_good_reg, a_good_next;
    logic [3:0]        b_good_reg, b_good_next;
    logic [SUM_W-1:0]  sum_reg, sum_next;
    logic [CNT_W-1:0]  nvalid_reg, nvalid_next;
    logic [CNT_W-1:0]  ninvalid_reg, ninvalid_next;
    logic [ITR_W-1:0]  itr_reg, itr_next;
    logic [SUM_W-1:0]  quo_reg, quo_next;
    logic [CNT_W-1:0]  rem_reg, rem_next;
    logic [CNT_W-1:0]  den_reg, den_next;
    logic              res_has_reg, res_has_next;
    logic              res_nosig_reg, res_nosig_next;
    logic              out_valid_reg, out_valid_next;
    logic              has_reg, has_next;
    logic [DIST_W-1:0] dist_reg, dist_next;
    logic              nosig_reg, nosig_next;
    logic [1:0]        oproto_reg, oproto_next;

    logic              in_acc;
    logic              cfg_wr;
    logic              a_rec, a_bad, b_rec, b_bad;
    logic [DIST_W-1:0] b_cm;
    ascii_flags_t      f;
    logic [18:0]       v;
    logic [3:0]        dig;
    logic [LEN_W:0]    len_inc;
    logic [CNT_W:0]    total;
    logic              a_take, b_take;
    logic [CNT_W:0]    sh;
    logic [CNT_W+1:0]  diff;
    logic [15:0]       oor_m;
    logic [15:0]       oor_d;

    assign in_stall  = (state_reg != ST_IDLE);
    assign in_acc    = in_valid && !in_stall;
    assign pready    = 1'b1;
    assign cfg_wr    = psel && penable && pwrite && pready;
    assign prdata    = paddr[PADDR_W-1] ? '0 : {{(PDATA_W-DIST_W){1'b0}}, max_reg};
    assign max_next  = (cfg_wr && !paddr[PADDR_W-1]) ? pwdata[DIST_W-1:0] : max_reg;

    assign out_valid   = out_valid_reg;
    assign has_reading = has_reg;
    assign range_cm    = dist_reg;
    assign lost_flag   = nosig_reg;
    assign protocol    = oproto_reg;

    // parsers
    always_comb
    begin
        a_val_next     = a_val_reg;
        a_flags_next   = a_flags_reg;
        a_len_next     = a_len_reg;
        high_next      = high_reg;
        high_seen_next = high_seen_reg;
        a_rec          = 1'b0;
        a_bad          = 1'b0;
        b_rec          = 1'b0;
        b_bad          = 1'b0;
        b_cm           = {1'b0, high_reg, byte_value[6:0]};
        f              = a_flags_reg;
        v              = '0;
        dig            = byte_value[3:0];
        len_inc        = {1'b0, a_len_reg} + 1'b1;
        if (in_acc && mode == MODE_BYTE &&
            (proto_reg == PROTO_UNKNOWN || proto_reg == PROTO_ASCII))
        begin
            if (byte_value == CH_CR)
            begin
                a_rec        = 1'b1;
                a_bad        = (a_flags_reg.neg && a_flags_reg.nz) ||
                               is_lost(a_val_reg, max_reg);
                a_val_next   = '0;
                a_flags_next = '0;
                a_len_next   = '0;
            end
            else if ((byte_value >= CH_ZERO && byte_value <= CH_NINE) ||
                     byte_value == CH_DOT || byte_value == CH_MINUS)
            begin
                if (!f.stop)
                begin
                    if (byte_value == CH_MINUS)
                    begin
                        if (a_len_reg == '0)
                            f.neg = 1'b1;
                        else
                            f.stop = 1'b1;
                    end
                    else if (byte_value == CH_DOT)
                    begin
                        if (f.dot)
                            f.stop = 1'b1;
                        else
                            f.dot = 1'b1;
                    end
                    else
                    begin
                        if (dig != 4'd0)
                            f.nz = 1'b1;
                        if (!f.dot)
                        begin
                            v = ({4'b0, a_val_reg} << 3) + ({4'b0, a_val_reg} << 1) +
                                19'(dig) * 19'd100;
                            a_val_next = sat_dist(v);
                        end
                        else if (f.frac_cnt < 2'd2)
                        begin
                            v = {4'b0, a_val_reg} +
                                ((f.frac_cnt == 2'd0) ? 19'(dig) * 19'd10 : 19'(dig));
                            a_val_next = sat_dist(v);
                            f.frac_cnt = f.frac_cnt + 2'd1;
                        end
                    end
                end
                a_flags_next = f;
                a_len_next   = len_inc[LEN_W-1:0];
                if (len_inc >= (LEN_W+1)'(LINE_LEN))
                begin
                    a_val_next   = '0;
                    a_flags_next = '0;
                    a_len_next   = '0;
                end
            end
        end
        if (in_acc && mode == MODE_BYTE &&
            (proto_reg == PROTO_UNKNOWN || proto_reg == PROTO_BINARY))
        begin
            if (byte_value[7])
            begin
                high_next      = byte_value[6:0];
                high_seen_next = 1'b1;
            end
            else
            begin
                b_rec          = high_seen_reg;
                b_bad          = is_lost(b_cm, max_reg);
                high_seen_next = 1'b0;
            end
        end
    end

    // batch bookkeeping, divider and result sequencing
    always_comb
    begin
        total          = {1'b0, nvalid_reg} + {1'b0, ninvalid_reg};
        a_take         = a_rec && (total < (CNT_W+1)'(MAX_BATCH));
        b_take         = b_rec && ((total + (CNT_W+1)'(a_take)) < (CNT_W+1)'(MAX_BATCH));
        sum_next       = sum_reg;
        nvalid_next    = nvalid_reg;
        ninvalid_next  = ninvalid_reg;
        a_good_next    = a_good_reg;
        b_good_next    = b_good_reg;
        proto_next     = proto_reg;
        state_next     = state_reg;
        itr_next       = itr_reg;
        quo_next       = quo_reg;
        rem_next       = rem_reg;
        den_next       = den_reg;
        res_has_next   = res_has_reg;
        res_nosig_next = res_nosig_reg;
        out_valid_next = out_valid_reg && out_stall;
        has_next       = has_reg;
        dist_next      = dist_reg;
        nosig_next     = nosig_reg;
        oproto_next    = oproto_reg;
        sh             = {rem_reg, quo_reg[SUM_W-1]};
        diff           = {1'b0, sh} - {2'b0, den_reg};
        oor_m          = {1'b0, max_reg} + OOR_ADD_CM;
        oor_d          = (oor_m > OOR_MIN_CM) ? oor_m : OOR_MIN_CM;

        if (a_take)
        begin
            if (a_bad)
                ninvalid_next = ninvalid_next + 1'b1;
            else
            begin
                sum_next    = sum_next + SUM_W'(a_val_reg);
                nvalid_next = nvalid_next + 1'b1;
                if (proto_reg == PROTO_UNKNOWN && a_good_reg <= GOOD_LOCK)
                    a_good_next = a_good_reg + 4'd1;
            end
        end
        if (b_take)
        begin
            if (b_bad)
                ninvalid_next = ninvalid_next + 1'b1;
            else
            begin
                sum_next    = sum_next + SUM_W'(b_cm);
                nvalid_next = nvalid_next + 1'b1;
                if (proto_reg == PROTO_UNKNOWN && b_good_reg <= GOOD_LOCK)
                    b_good_next = b_good_reg + 4'd1;
            end
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_acc && mode == MODE_END)
                begin
                    if (proto_reg == PROTO_UNKNOWN)
                    begin
                        if (b_good_reg > GOOD_LOCK)
                            proto_next = PROTO_BINARY;
                        else if (a_good_reg > GOOD_LOCK)
                            proto_next = PROTO_ASCII;
                    end
                    res_has_next   = (nvalid_reg != '0) || (ninvalid_reg != '0);
                    res_nosig_next = (nvalid_reg == '0) && (ninvalid_reg != '0);
                    den_next       = nvalid_reg;
                    rem_next       = '0;
                    itr_next       = ITR_W'(SUM_W - 1);
                    if (nvalid_reg != '0)
                    begin
                        quo_next   = sum_reg;
                        state_next = ST_DIV;
                    end
                    else
                    begin
                        quo_next   = (ninvalid_reg != '0) ? SUM_W'(sat_dist({3'b0, oor_d}))
                                                          : '0;
                        state_next = ST_FIN;
                    end
                    sum_next      = '0;
                    nvalid_next   = '0;
                    ninvalid_next = '0;
                end
            end
            ST_DIV:
            begin
                if (!diff[CNT_W+1])
                begin
                    rem_next = diff[CNT_W-1:0];
                    quo_next = {quo_reg[SUM_W-2:0], 1'b1};
                end
                else
                begin
                    rem_next = sh[CNT_W-1:0];
                    quo_next = {quo_reg[SUM_W-2:0], 1'b0};
                end
                itr_next = itr_reg - 1'b1;
                if (itr_reg == '0)
                    state_next = ST_FIN;
            end
            ST_FIN:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    has_next       = res_has_reg;
                    nosig_next     = res_nosig_reg;
                    dist_next      = (quo_reg > SUM_W'(DIST_SAT)) ? DIST_SAT
                                                                  : quo_reg[DIST_W-1:0];
                    oproto_next    = proto_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_reg       <= MAX_DIST_RST;
            state_reg     <= ST_IDLE;
            proto_reg     <= PROTO_UNKNOWN;
            a_val_reg     <= '0;
            a_flags_reg   <= '0;
            a_len_reg     <= '0;
            high_reg      <= '0;
            high_seen_reg <= 1'b0;
            a_good_reg    <= '0;
            b_good_reg    <= '0;
            sum_reg       <= '0;
            nvalid_reg    <= '0;
            ninvalid_reg  <= '0;
            itr_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            max_reg       <= max_next;
            state_reg     <= state_next;
            proto_reg     <= proto_next;
            a_val_reg     <= a_val_next;
            a_flags_reg   <= a_flags_next;
            a_len_reg     <= a_len_next;
            high_reg      <= high_next;
            high_seen_reg <= high_seen_next;
            a_good_reg    <= a_good_next;
            b_good_reg    <= b_good_next;
            sum_reg       <= sum_next;
            nvalid_reg    <= nvalid_next;
            ninvalid_reg  <= ninvalid_next;
            itr_reg       <= itr_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg       <= quo_next;
        rem_reg       <= rem_next;
        den_reg       <= den_next;
        res_has_reg   <= res_has_next;
        res_nosig_reg <= res_nosig_next;
        has_reg       <= has_next;
        dist_reg      <= dist_next;
        nosig_reg     <= nosig_next;
        oproto_reg    <= oproto_next;
    end

`include "assert_macros.svh"

    `RDPP_ASSERT(a_batch_bound, (total <= (CNT_W+1)'(MAX_BATCH)), "batch count over limit")
    `RDPP_ASSERT(a_good_sat, (a_good_reg <= GOOD_MAX && b_good_reg <= GOOD_MAX), "good count")
    `RDPP_ASSERT(a_proto_sticky, (proto_reg != PROTO_UNKNOWN |=> $stable(proto_reg)), "lock")
    `RDPP_ASSERT(a_rem_bound, (state_reg == ST_DIV |-> rem_reg < den_reg), "remainder bound")
    `RDPP_ASSERT(a_out_from_fin, ($rose(out_valid_reg) |-> $past(state_reg) == ST_FIN), "fin")
    `RDPP_ASSERT_NEVER(a_nosig_has, (out_valid_reg && nosig_reg && !has_reg), "lost flag")

endmodule

[sim/rangefinder_dual_protocol_parser_tb.sv]
`timescale 1ns / 100ps
// Self-checking bench for the rangefinder byte parser: directed rows, random byte streams.
module rangefinder_dual_protocol_parser_tb;
    import rdpp_pkg::*;

    localparam int SETTLE       = 64;
    localparam int CYCLE_LIMIT  = 3000000;
    localparam int PHASE_WORDS  = 168;
    localparam int N_PHASES     = 10;
    localparam int PRESS_AFTER  = 25;
    localparam int PRESS_CYCLES = 400;
    localparam int DRAIN_LIMIT  = 20000;
    localparam logic [PADDR_W-1:0] REG_MAX_DIST = '0;

    typedef struct packed {
        logic              has;
        logic [DIST_W-1:0] cm;
        logic              nosig;
        logic [1:0]        proto;
    } report_t;

    typedef struct packed {
        logic       m;
        logic [7:0] b;
        logic       typed;
        report_t    want;
    } dir_row_t;

    logic               clk;
    logic               rst_n;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [PDATA_W-1:0] pwdata;
    logic [PDATA_W-1:0] prdata;
    logic               pready;
    logic               in_valid;
    logic               in_stall;
    logic               mode;
    logic [7:0]         byte_value;
    logic               out_valid;
    logic               out_stall;
    logic               has_reading;
    logic [DIST_W-1:0]  range_cm;
    logic               lost_flag;
    logic [1:0]         protocol;

    // predictor state
    logic [1:0]        proto_lock;
    logic [DIST_W-1:0] max_cm;
    int unsigned       line_val;
    ascii_flags_t      line_fl;
    int unsigned       line_n;
    logic [6:0]        hi_half;
    logic              hi_seen;
    int unsigned       ascii_good;
    int unsigned       binary_good;
    int unsigned       sum_cm;
    int unsigned       n_valid;
    int unsigned       n_invalid;

    report_t  batch_reports[$];
    dir_row_t dir_tab[$];

    int errs;
    int results_seen;
    int words_sent;
    int cycles;
    int tx_quiet;
    int rx_quiet;
    bit lean_binary;

    int unsigned cfg_plan[N_PHASES] = '{0, 30000, 12900, 12901, 15900, 15901,
                                         22900, 24901, 0, 4000};

    rangefinder_dual_protocol_parser uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .mode        (mode),
        .byte_value  (byte_value),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .has_reading (has_reading),
        .range_cm    (range_cm),
        .lost_flag   (lost_flag),
        .protocol    (protocol)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    function automatic int pause_len(inout int quiet);
        int r;
        if (quiet > 0)
        begin
            quiet--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 3)
            quiet = $urandom_range(20, 80);
        if (r < 55)
            return 0;
        if (r < 88)
            return $urandom_range(1, 3);
        if (r < 98)
            return $urandom_range(4, 12);
        return $urandom_range(20, 40);
    endfunction

    function automatic logic [7:0] rand_digit();
        return CH_ZERO + 8'($urandom_range(0, 9));
    endfunction

    function automatic bit lost_code(input int unsigned cm);
        if (cm < int'(max_cm) + int'(OOR_ADD_CM))
            return 1'b0;
        return cm == LOST_CODE0 || cm == LOST_CODE1 || cm == LOST_CODE2 || cm == LOST_CODE3;
    endfunction

    task automatic clear_line();
        line_val = 0;
        line_fl  = '0;
        line_n   = 0;
    endtask

    task automatic tally(input int unsigned cm, input bit bad, input bit from_ascii);
        if (n_valid + n_invalid < MAX_BATCH_DEF)
        begin
            if (bad)
                n_invalid++;
            else
            begin
                sum_cm += cm;
                n_valid++;
                if (proto_lock == PROTO_UNKNOWN)
                begin
                    if (from_ascii && ascii_good <= GOOD_LOCK)
                        ascii_good++;
                    else if (!from_ascii && binary_good <= GOOD_LOCK)
                        binary_good++;
                end
            end
        end
    endtask

    task automatic ascii_keep(input logic [7:0] c);
        ascii_flags_t f;
        int unsigned d;
        int unsigned v;
        f = line_fl;
        if (!f.stop)
        begin
            if (c == CH_MINUS)
            begin
                if (line_n == 0)
                    f.neg = 1'b1;
                else
                    f.stop = 1'b1;
            end
            else if (c == CH_DOT)
            begin
                if (f.dot)
                    f.stop = 1'b1;
                else
                    f.dot = 1'b1;
            end
            else
            begin
                d = c - CH_ZERO;
                if (d != 0)
                    f.nz = 1'b1;
                if (!f.dot)
                begin
                    v = line_val * 10 + d * 100;
                    line_val = (v > 32767) ? 32767 : v;
                end
                else if (f.frac_cnt < 2)
                begin
                    v = line_val + ((f.frac_cnt == 0) ? d * 10 : d);
                    line_val = (v > 32767) ? 32767 : v;
                    f.frac_cnt = f.frac_cnt + 2'd1;
                end
            end
        end
        line_fl = f;
        line_n++;
        if (line_n >= LINE_LEN_DEF)
            clear_line();
    endtask

    // advances the parser by one accepted word; end words queue a batch report
    task automatic parse_word(input logic m, input logic [7:0] b);
        report_t     r;
        int unsigned v;
        if (m == MODE_BYTE)
        begin
            if (proto_lock != PROTO_BINARY)
            begin
                if (b == CH_CR)
                begin
                    tally(line_val, (line_fl.neg && line_fl.nz) || lost_code(line_val), 1'b1);
                    clear_line();
                end
                else if ((b >= CH_ZERO && b <= CH_NINE) || b == CH_DOT || b == CH_MINUS)
                    ascii_keep(b);
            end
            if (proto_lock != PROTO_ASCII)
            begin
                if (b[7])
                begin
                    hi_half = b[6:0];
                    hi_seen = 1'b1;
                end
                else
                begin
                    if (hi_seen)
                        tally({hi_half, b[6:0]}, lost_code({hi_half, b[6:0]}), 1'b0);
                    hi_seen = 1'b0;
                end
            end
        end
        else
        begin
            if (proto_lock == PROTO_UNKNOWN)
            begin
                if (binary_good > GOOD_LOCK)
                    proto_lock = PROTO_BINARY;
                else if (ascii_good > GOOD_LOCK)
                    proto_lock = PROTO_ASCII;
            end
            r = '0;
            if (n_valid > 0)
            begin
                r.has = 1'b1;
                r.cm  = DIST_W'(sum_cm / n_valid);
            end
            else if (n_invalid > 0)
            begin
                v = int'(max_cm) + int'(OOR_ADD_CM);
                if (v < OOR_MIN_CM)
                    v = OOR_MIN_CM;
                if (v > DIST_SAT)
                    v = DIST_SAT;
                r.has   = 1'b1;
                r.nosig = 1'b1;
                r.cm    = DIST_W'(v);
            end
            r.proto = proto_lock;
            batch_reports.push_back(r);
            sum_cm    = 0;
            n_valid   = 0;
            n_invalid = 0;
        end
    endtask

    task automatic push_word(input logic m, input logic [7:0] b);
        int g;
        g = pause_len(tx_quiet);
        if (g > 0)
        begin
            in_valid <= 1'b0;
            repeat (g) @(negedge clk);
        end
        in_valid   <= 1'b1;
        mode       <= m;
        byte_value <= b;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        parse_word(m, b);
        words_sent++;
        @(negedge clk);
    endtask

    task automatic settle_idle();
        in_valid <= 1'b0;
        while (batch_reports.size() != 0)
            @(negedge clk);
        repeat (SETTLE) @(negedge clk);
    endtask

    task automatic cfg_read(input logic [DIST_W-1:0] want);
        psel    <= 1'b1;
        pwrite  <= 1'b0;
        penable <= 1'b0;
        paddr   <= REG_MAX_DIST;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        if (prdata[DIST_W-1:0] !== want)
        begin
            $error("max_distance_cm: expected %0d, got %0d", want, prdata[DIST_W-1:0]);
            errs++;
        end
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(negedge clk);
    endtask

    task automatic cfg_write(input logic [DIST_W-1:0] v);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= REG_MAX_DIST;
        pwdata  <= PDATA_W'(v);
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        max_cm = v;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge clk);
        cfg_read(v);
    endtask

    task automatic send_binary_reading();
        logic [13:0] v;
        int k;
        k = $urandom_range(0, 15);
        case (k)
            0:       v = LOST_CODE0[13:0];
            1:       v = LOST_CODE1[13:0];
            2:       v = '0;
            3:       v = '1;
            default: v = 14'($urandom_range(0, 16383));
        endcase
        k = $urandom_range(0, 9);
        if (k == 0)
            push_word(MODE_BYTE, {1'b1, 7'($urandom_range(0, 127))});
        if (k != 1)
            push_word(MODE_BYTE, {1'b1, v[13:7]});
        push_word(MODE_BYTE, {1'b0, v[6:0]});
    endtask

    task automatic send_ascii_line();
        logic [7:0] line_q[$];
        logic [7:0] junk;
        int k;
        int code;
        k = $urandom_range(0, 19);
        if (k < 3)
        begin
            // lost-signal codes written in metres
            case ($urandom_range(0, 3))
                0:       code = int'(LOST_CODE0) / 100;
                1:       code = int'(LOST_CODE1) / 100;
                2:       code = int'(LOST_CODE2) / 100;
                default: code = int'(LOST_CODE3) / 100;
            endcase
            line_q.push_back(CH_ZERO + 8'(code / 100));
            line_q.push_back(CH_ZERO + 8'((code / 10) % 10));
            line_q.push_back(CH_ZERO + 8'(code % 10));
            if ($urandom_range(0, 1))
            begin
                line_q.push_back(CH_DOT);
                line_q.push_back(CH_ZERO);
            end
        end
        else if (k < 5)
        begin
            repeat ($urandom_range(LINE_LEN_DEF - 2, LINE_LEN_DEF + 6))
                line_q.push_back(rand_digit());
        end
        else
        begin
            if ($urandom_range(0, 6) == 0)
                line_q.push_back(CH_MINUS);
            repeat ($urandom_range(0, 6))
                line_q.push_back(rand_digit());
            if ($urandom_range(0, 1))
            begin
                line_q.push_back(CH_DOT);
                repeat ($urandom_range(0, 4))
                    line_q.push_back(rand_digit());
            end
        end
        foreach (line_q[i])
        begin
            if ($urandom_range(0, 11) == 0)
            begin
                case ($urandom_range(0, 5))
                    0:       junk = "x";
                    1:       junk = " ";
                    2:       junk = "+";
                    3:       junk = CH_MINUS;
                    4:       junk = CH_DOT;
                    default: junk = 8'h0a;
                endcase
                push_word(MODE_BYTE, junk);
            end
            push_word(MODE_BYTE, line_q[i]);
        end
        if ($urandom_range(0, 19) != 0)
            push_word(MODE_BYTE, CH_CR);
    endtask

    task automatic add_byte(input logic [7:0] b);
        dir_tab.push_back('{MODE_BYTE, b, 1'b0, report_t'('0)});
    endtask

    task automatic add_end(input bit typed, input logic has, input logic [DIST_W-1:0] cm,
                           input logic nosig);
        dir_tab.push_back('{MODE_END, 8'h00, typed, report_t'({has, cm, nosig, PROTO_UNKNOWN})});
    endtask

    // result checker
    always @(posedge clk)
    begin
        report_t w;
        if (rst_n && out_valid && !out_stall)
        begin
            results_seen++;
            if (batch_reports.size() == 0)
            begin
                $error("batch report with none expected");
                errs++;
            end
            else
            begin
                w = batch_reports.pop_front();
                if (has_reading !== w.has)
                begin
                    $error("has_reading: expected %0d, got %0d", w.has, has_reading);
                    errs++;
                end
                if (range_cm !== w.cm)
                begin
                    $error("range_cm: expected %0d, got %0d", w.cm, range_cm);
                    errs++;
                end
                if (lost_flag !== w.nosig)
                begin
                    $error("lost_flag: expected %0d, got %0d", w.nosig, lost_flag);
                    errs++;
                end
                if (protocol !== w.proto)
                begin
                    $error("protocol: expected %0d, got %0d", w.proto, protocol);
                    errs++;
                end
            end
        end
    end

    // receiver stalls, with one long hold-off
    initial
    begin
        int  g;
        bit  pressed;
        pressed = 1'b0;
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            if (!pressed && results_seen >= PRESS_AFTER)
            begin
                out_stall <= 1'b1;
                repeat (PRESS_CYCLES) @(negedge clk);
                pressed = 1'b1;
                out_stall <= 1'b0;
                @(negedge clk);
            end
            else
            begin
                g = pause_len(rx_quiet);
                if (g > 0)
                begin
                    out_stall <= 1'b1;
                    repeat (g) @(negedge clk);
                end
                out_stall <= 1'b0;
                @(negedge clk);
            end
        end
    end

    initial
    begin
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("rangefinder_dual_protocol_parser verification failed");
        $finish;
    end

    initial
    begin
        int r;
        int start;
        int bin_share;
        int n;
        psel       = 1'b0;
        penable    = 1'b0;
        pwrite     = 1'b0;
        paddr      = '0;
        pwdata     = '0;
        in_valid   = 1'b0;
        mode       = MODE_BYTE;
        byte_value = '0;
        out_stall  = 1'b0;
        rst_n      = 1'b0;
        errs         = 0;
        results_seen = 0;
        words_sent   = 0;
        tx_quiet     = 0;
        rx_quiet     = 0;

        proto_lock  = PROTO_UNKNOWN;
        max_cm      = MAX_DIST_RST;
        clear_line();
        hi_half     = '0;
        hi_seen     = 1'b0;
        ascii_good  = 0;
        binary_good = 0;
        sum_cm      = 0;
        n_valid     = 0;
        n_invalid   = 0;

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        cfg_read(MAX_DIST_RST);

        // empty batch, ASCII with dropped third decimal, binary full scale,
        // negative line, lost-signal code, stray low byte, minus zero
        add_end(1'b1, 1'b0, '0, 1'b0);
        add_byte("1");
        add_byte("2");
        add_byte(CH_DOT);
        add_byte("3");
        add_byte("4");
        add_byte("5");
        add_byte(CH_CR);
        add_byte(8'hff);
        add_byte(8'h7f);
        add_end(1'b0, 1'b0, '0, 1'b0);
        add_byte(CH_MINUS);
        add_byte("5");
        add_byte(CH_CR);
        add_end(1'b1, 1'b1, DIST_W'(OOR_MIN_CM), 1'b1);
        add_byte({1'b1, LOST_CODE0[13:7]});
        add_byte({1'b0, LOST_CODE0[6:0]});
        add_end(1'b1, 1'b1, DIST_W'(OOR_MIN_CM), 1'b1);
        add_byte(8'h00);
        add_byte(CH_MINUS);
        add_byte(CH_ZERO);
        add_byte(CH_CR);
        add_end(1'b1, 1'b1, '0, 1'b0);

        foreach (dir_tab[i])
        begin
            push_word(dir_tab[i].m, dir_tab[i].b);
            if (dir_tab[i].typed)
                batch_reports[batch_reports.size() - 1] = dir_tab[i].want;
        end

        lean_binary = $urandom_range(0, 1);
        bin_share = lean_binary ? 45 : 20;
        for (int ph = 0; ph < N_PHASES; ph++)
        begin
            settle_idle();
            if (ph == 8)
                cfg_write(DIST_W'($urandom_range(0, 30000)));
            else
                cfg_write(DIST_W'(cfg_plan[ph]));
            start = words_sent;
            while (words_sent - start < PHASE_WORDS)
            begin
                r = $urandom_range(0, 99);
                if (r < 15)
                    push_word(MODE_END, 8'($urandom));
                else if (r < 15 + bin_share)
                    send_binary_reading();
                else if (r < 85)
                    send_ascii_line();
                else
                    push_word(MODE_BYTE, 8'($urandom));
            end
            push_word(MODE_END, 8'($urandom));
        end

        in_valid <= 1'b0;
        n = 0;
        while (batch_reports.size() != 0 && n < DRAIN_LIMIT)
        begin
            @(negedge clk);
            n++;
        end
        if (batch_reports.size() != 0)
        begin
            $error("%0d batch reports never arrived", batch_reports.size());
            errs++;
        end
        repeat (SETTLE) @(negedge clk);
        if (errs == 0)
            $display("rangefinder_dual_protocol_parser verification clean");
        else
            $display("rangefinder_dual_protocol_parser verification failed");
        $finish;
    end

endmodule
